// ----- design/m4m_pkg.sv -----
package m4m_pkg;

	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int ADDR_W    = $clog2(DIM * DIM);
	localparam int PROD_W    = 2 * VAL_W;
	// A floored product keeps PROD_W - FRAC_BITS bits; DIM of them need clog2(DIM) more.
	localparam int ACC_W     = PROD_W - FRAC_BITS + $clog2(DIM);

	typedef enum logic [1:0] {
		CMD_WRITE_A = 2'd0,
		CMD_WRITE_B = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		logic             first;
		logic             last;
	} tag_t;

	typedef struct packed {
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] row;
		logic [VAL_W-1:0] value;
		logic             ovf;
	} res_t;

endpackage

// ----- design/m4m_mac.sv -----
module m4m_mac (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       in_vld,
	input  logic signed [m4m_pkg::VAL_W-1:0] a,
	input  logic signed [m4m_pkg::VAL_W-1:0] b,
	input  m4m_pkg::tag_t              in_tag,
	output logic                       done,
	output m4m_pkg::res_t              res
);
	import m4m_pkg::*;

	logic                     vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	tag_t                     tag_s2;
	logic                     done_s3;
	logic signed [ACC_W-1:0]  sum_s3;
	tag_t                     tag_s3;
	logic signed [ACC_W-1:0]  term;
	logic [ACC_W-VAL_W:0]     sum_hi;
	logic                     ovf;

	// The arithmetic shift rounds each product toward minus infinity.
	assign term = ACC_W'(prod_s2 >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			done_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2  <= in_vld;
			done_s3 <= vld_s2 && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PROD_W'(a) * PROD_W'(b);
			tag_s2  <= in_tag;
			if (vld_s2) begin
				sum_s3 <= tag_s2.first ? term : sum_s3 + term;
				tag_s3 <= tag_s2;
			end
		end
	end

	// The sum fits in 32 bits only when all bits from bit 31 upward agree.
	assign sum_hi = sum_s3[ACC_W-1:VAL_W-1];
	assign ovf    = !((&sum_hi) || !(|sum_hi));

	always_comb begin
		res.col = tag_s3.col;
		res.row = tag_s3.row;
		res.ovf = ovf;
		if (!ovf) begin
			res.value = sum_s3[VAL_W-1:0];
		end else if (sum_s3[ACC_W-1]) begin
			res.value = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			res.value = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	assign done = done_s3;

endmodule

// ----- design/mat4_multiply.sv -----
// Channel   Direction  Handshake           Beat contents
// input     in         in_valid/in_stall   command, column, row, value
// output    out        out_valid/out_stall out_column, out_row, product_value, overflow, last
//
// A compute issues DIM^3 = 64 multiply-accumulates on a single multiplier, one per cycle
// while the output does not stall, and it holds the input off until the last product
// element has been taken.
// Reset clears both matrices at once through per-entry valid bits; no clearing pass.
// An output stall while a result is pending freezes the whole compute pipeline, memory reads included.
module mat4_multiply (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 command,
	input  logic [1:0]                 column,
	input  logic [1:0]                 row,
	input  logic signed [m4m_pkg::VAL_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 out_column,
	output logic [1:0]                 out_row,
	output logic signed [m4m_pkg::VAL_W-1:0] product_value,
	output logic                       overflow,
	output logic                       last
);
	import m4m_pkg::*;

	logic [VAL_W-1:0]  mem_a [DIM*DIM];
	logic [VAL_W-1:0]  mem_b [DIM*DIM];
	logic [DIM*DIM-1:0] a_vld_q;
	logic [DIM*DIM-1:0] b_vld_q;

	state_t            state_q;
	state_t            state_d;
	logic [IDX_W-1:0]  c_q;
	logic [IDX_W-1:0]  r_q;
	logic [IDX_W-1:0]  k_q;

	logic              accept_in;
	logic              in_range;
	logic              wr_a;
	logic              wr_b;
	logic              start;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic              issue;
	logic              issue_end;
	logic              adv;
	logic              out_take;

	logic              vld_s1;
	logic [VAL_W-1:0]  a_s1;
	logic [VAL_W-1:0]  b_s1;
	logic              av_s1;
	logic              bv_s1;
	tag_t              tag_s1;
	tag_t              tag_rd;
	logic signed [VAL_W-1:0] a_op;
	logic signed [VAL_W-1:0] b_op;

	logic              mac_done;
	res_t              mac_res;

	logic              out_valid_q;
	res_t              out_q;

	assign accept_in = in_valid && !in_stall;
	assign in_range  = (int'(column) < DIM) && (int'(row) < DIM);
	assign wr_a      = accept_in && in_range && (command == CMD_WRITE_A);
	assign wr_b      = accept_in && in_range && (command == CMD_WRITE_B);
	assign start     = accept_in && (command == CMD_COMPUTE);
	assign wr_addr   = ADDR_W'(int'(column) * DIM + int'(row));
	assign rd_addr_a = ADDR_W'(int'(k_q) * DIM + int'(r_q));
	assign rd_addr_b = ADDR_W'(int'(c_q) * DIM + int'(k_q));

	assign out_take  = out_valid_q && !out_stall;
	assign adv       = !out_valid_q || !out_stall;
	assign issue     = (state_q == ST_ISSUE);
	assign issue_end = (int'(c_q) == DIM - 1) && (int'(r_q) == DIM - 1) &&
	                   (int'(k_q) == DIM - 1);

	// Memories. Reads advance only with the pipeline so a stall holds the read data.
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= value;
		end
		if (wr_b) begin
			mem_b[wr_addr] <= value;
		end
		if (adv) begin
			a_s1   <= mem_a[rd_addr_a];
			b_s1   <= mem_b[rd_addr_b];
			av_s1  <= a_vld_q[rd_addr_a];
			bv_s1  <= b_vld_q[rd_addr_b];
			tag_s1 <= tag_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_q <= '0;
			b_vld_q <= '0;
		end else begin
			if (wr_a) begin
				a_vld_q[wr_addr] <= 1'b1;
			end
			if (wr_b) begin
				b_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		tag_rd.col   = c_q;
		tag_rd.row   = r_q;
		tag_rd.first = (k_q == '0);
		tag_rd.last  = (int'(k_q) == DIM - 1);
	end

	// An entry not written since reset reads as zero through its cleared valid bit.
	assign a_op = av_s1 ? a_s1 : '0;
	assign b_op = bv_s1 ? b_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			c_q     <= '0;
			r_q     <= '0;
			k_q     <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				c_q <= '0;
				r_q <= '0;
				k_q <= '0;
			end else if (issue && adv) begin
				if (int'(k_q) == DIM - 1) begin
					k_q <= '0;
					if (int'(r_q) == DIM - 1) begin
						r_q <= '0;
						c_q <= c_q + 1'b1;
					end else begin
						r_q <= r_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			if (adv) begin
				vld_s1 <= issue;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (start) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (adv && issue_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_take && last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	m4m_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_vld (vld_s1),
		.a      (a_op),
		.b      (b_op),
		.in_tag (tag_s1),
		.done   (mac_done),
		.res    (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= mac_done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mac_done) begin
			out_q <= mac_res;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_column    = 2'(out_q.col);
	assign out_row       = 2'(out_q.row);
	assign product_value = out_q.value;
	assign overflow      = out_q.ovf;
	assign last          = (int'(out_q.col) == DIM - 1) && (int'(out_q.row) == DIM - 1);

	// A pending result means a compute is still in flight, so the input must be held off.
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result pending while input is open");

	a_start_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command == CMD_COMPUTE) |=> in_stall)
		else $error("compute accepted but input not held off");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!in_stall && !out_valid))
		else $error("block not idle after final product element");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |->
			(product_value == 32'sh7FFFFFFF || product_value == 32'sh80000000))
		else $error("overflow flagged on an unsaturated value");

endmodule

// ----- test/mat4_checker.sv -----
module mat4_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       command,
	input  logic [1:0]                       column,
	input  logic [1:0]                       row,
	input  logic signed [m4m_pkg::VAL_W-1:0] value,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [1:0]                       out_column,
	input  logic [1:0]                       out_row,
	input  logic signed [m4m_pkg::VAL_W-1:0] product_value,
	input  logic                             overflow,
	input  logic                             last,
	output int                               errors,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import m4m_pkg::*;

	localparam logic signed [63:0] SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SUM_MIN = -64'sh0000_0000_8000_0000;

	typedef struct {
		logic [1:0]              col;
		logic [1:0]              row;
		logic signed [VAL_W-1:0] value;
		logic                    ovf;
		logic                    last;
	} element_t;

	logic signed [VAL_W-1:0] a_store [DIM*DIM];
	logic signed [VAL_W-1:0] b_store [DIM*DIM];
	element_t                product_q [$];

	// Dot product of row r of A with column c of B, each term floored by the
	// arithmetic shift, then clamped to the 32-bit range.
	function automatic element_t product_element(int c, int r);
		element_t          e;
		logic signed [63:0] term;
		logic signed [63:0] sum;
		sum = '0;
		for (int k = 0; k < DIM; k++) begin
			term = a_store[k*DIM + r] * b_store[c*DIM + k];
			sum += term >>> FRAC_BITS;
		end
		e.col  = c[1:0];
		e.row  = r[1:0];
		e.ovf  = 1'b1;
		e.last = (c == DIM - 1) && (r == DIM - 1);
		if (sum > SUM_MAX) begin
			e.value = 32'sh7FFF_FFFF;
		end else if (sum < SUM_MIN) begin
			e.value = 32'sh8000_0000;
		end else begin
			e.value = sum[31:0];
			e.ovf   = 1'b0;
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		element_t want;
		if (!arst_n) begin
			for (int i = 0; i < DIM*DIM; i++) begin
				a_store[i] = '0;
				b_store[i] = '0;
			end
			product_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (product_q.size() == 0) begin
					$display("%0t: unexpected product beat (%0d,%0d) value %h ovf %b last %b",
						$time, out_column, out_row, product_value, overflow, last);
					errors++;
				end else begin
					want = product_q.pop_front();
					if (out_column !== want.col || out_row !== want.row ||
						product_value !== want.value || overflow !== want.ovf ||
						last !== want.last) begin
						$display("%0t: want (%0d,%0d) %h o%b l%b, got (%0d,%0d) %h o%b l%b",
							$time, want.col, want.row, want.value, want.ovf, want.last,
							out_column, out_row, product_value, overflow, last);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (command)
					CMD_WRITE_A: a_store[column*DIM + row] = value;
					CMD_WRITE_B: b_store[column*DIM + row] = value;
					CMD_COMPUTE: begin
						for (int c = 0; c < DIM; c++)
							for (int r = 0; r < DIM; r++)
								product_q.push_back(product_element(c, r));
					end
					default: ;
				endcase
			end
			pending = product_q.size();
		end
	end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import m4m_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int         LOAD_ITEMS = 430;
	localparam int         MAX_GAP    = 12;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              command;
	logic [1:0]              column;
	logic [1:0]              row;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_stall;
	logic [1:0]              out_column;
	logic [1:0]              out_row;
	logic signed [VAL_W-1:0] product_value;
	logic                    overflow;
	logic                    last;
	int                      errors;
	int                      pending;

	// While calm is set neither side inserts idle cycles.
	bit                      calm;
	int                      stall_left;

	mat4_multiply uut (.*);

	mat4_checker product_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	// Output side: after each accepted beat, hold stall for a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			n = calm ? 0 : $urandom_range(0, MAX_GAP);
			stall_left <= n;
			out_stall  <= (n != 0);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left > 1);
		end
	end

	task automatic send_beat(input logic [1:0] cmd, input logic [1:0] c, input logic [1:0] r,
		input logic [31:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		column   <= c;
		row      <= r;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Mostly small Q16.16 values that keep sums in range, with raw words and extremes mixed in.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'hFFFF_FFFF;
					default: return 32'h0000_0000;
				endcase
			end
			default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		endcase
	endfunction

	initial begin
		int sent;
		int roll;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		command  = CMD_WRITE_A;
		column   = '0;
		row      = '0;
		value    = '0;
		calm     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Product of the cleared stores, then a command that does nothing.
		send_beat(CMD_COMPUTE, 2'd0, 2'd0, 32'h0);
		send_beat(CMD_UNUSED, 2'd1, 2'd2, 32'hDEAD_BEEF);
		// Largest times largest saturates high.
		send_beat(CMD_WRITE_A, 2'd0, 2'd0, 32'h7FFF_FFFF);
		send_beat(CMD_WRITE_B, 2'd0, 2'd0, 32'h7FFF_FFFF);
		send_beat(CMD_COMPUTE, 2'd0, 2'd0, 32'h0);
		// Largest times most negative saturates low.
		send_beat(CMD_WRITE_B, 2'd0, 2'd0, 32'h8000_0000);
		send_beat(CMD_COMPUTE, 2'd0, 2'd0, 32'h0);
		// Most negative squared overflows high; -eps times +eps floors to -eps.
		send_beat(CMD_WRITE_A, 2'd0, 2'd0, 32'h8000_0000);
		send_beat(CMD_WRITE_A, 2'd3, 2'd3, 32'hFFFF_FFFF);
		send_beat(CMD_WRITE_B, 2'd3, 2'd3, 32'h0000_0001);
		send_beat(CMD_COMPUTE, 2'd0, 2'd0, 32'h0);
		// Ordinary values across every index.
		send_beat(CMD_WRITE_A, 2'd0, 2'd0, 32'h0001_0000);
		send_beat(CMD_WRITE_A, 2'd1, 2'd2, 32'hFFFE_8000);
		send_beat(CMD_WRITE_A, 2'd2, 2'd1, 32'h0003_4000);
		send_beat(CMD_WRITE_A, 2'd3, 2'd0, 32'h1234_5678);
		send_beat(CMD_WRITE_B, 2'd0, 2'd3, 32'hFFFF_0000);
		send_beat(CMD_WRITE_B, 2'd1, 2'd1, 32'h0002_0000);
		send_beat(CMD_WRITE_B, 2'd2, 2'd0, 32'hEDCB_A988);
		send_beat(CMD_WRITE_B, 2'd3, 2'd2, 32'h0000_8000);
		send_beat(CMD_COMPUTE, 2'd3, 2'd3, 32'hFFFF_FFFF);

		sent = 0;
		while (sent < LOAD_ITEMS) begin
			if ($urandom_range(0, 39) == 0)
				calm = !calm;
			roll = $urandom_range(0, 99);
			if (roll < 3) begin
				send_beat(CMD_UNUSED, 2'($urandom()), 2'($urandom()), $urandom());
			end else if (roll < 12) begin
				send_beat(CMD_COMPUTE, 2'($urandom()), 2'($urandom()), $urandom());
				sent++;
			end else begin
				send_beat(roll[0] ? CMD_WRITE_B : CMD_WRITE_A, 2'($urandom()),
					2'($urandom()), pick_value());
				sent++;
			end
		end
		in_valid <= 1'b0;

		// Let the checker see the last accepted beat before looking at its count.
		@(negedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
